/* design/lru_pkg.sv */
// Shared constants and types for the LRU page replacement core.
package lru_pkg;

    // Default build sizes
    localparam int DEF_MAX_FRAMES = 16;
    localparam int DEF_PAGE_WIDTH = 16;

    // Frame count register
    localparam int          FC_WIDTH = 5;
    localparam logic [4:0]  FC_RESET = 5'd4;

    // Fault counter
    localparam int          FAULT_WIDTH = 32;
    localparam logic [31:0] FAULT_MAX   = 32'hFFFF_FFFF;

    // Position of a slot relative to the current occupancy
    typedef struct packed {
        logic live;   // slot holds a resident page
        logic last;   // slot is the most recent resident slot
        logic free;   // slot is the first empty slot
    } t_slot_pos;

    // Per-transaction command broadcast to every slot cell
    typedef struct packed {
        logic accept; // an input transaction updates the store this cycle
        logic hit;    // the page is resident somewhere in the row
        logic evict;  // a miss on a full store drops the least recent page
    } t_slot_cmd;

endpackage

/* design/lru_cell.sv */
// One recency slot: holds a page, compares it, and shifts toward slot 0.
module lru_cell #(
    parameter int PAGE_WIDTH = lru_pkg::DEF_PAGE_WIDTH
) (
    input  logic                  i_clk,
    input  logic [PAGE_WIDTH-1:0] i_page,
    input  lru_pkg::t_slot_pos    i_pos,
    input  lru_pkg::t_slot_cmd    i_cmd,
    input  logic                  i_hit_chain,
    input  logic [PAGE_WIDTH-1:0] i_next_page,
    output logic                  o_hit_chain,
    output logic                  o_match,
    output logic [PAGE_WIDTH-1:0] o_page
);

    logic [PAGE_WIDTH-1:0] r_page;
    logic [PAGE_WIDTH-1:0] n_page;
    logic                  w_shift;
    logic                  w_load;

    // Compare against the referenced page and extend the hit chain upward
    assign o_match     = i_pos.live && (r_page == i_page);
    assign o_hit_chain = i_hit_chain | o_match;

    // Close the gap: slots at or above the removed one take their upper neighbor
    assign w_shift = i_cmd.accept && (o_hit_chain || i_cmd.evict) &&
                     i_pos.live && !i_pos.last;

    // Place the referenced page in the most recent slot
    assign w_load = i_cmd.accept &&
                    ((i_pos.last && (i_cmd.hit || i_cmd.evict)) ||
                     (i_pos.free && !i_cmd.hit && !i_cmd.evict));

    always_comb begin
        priority if (w_load) begin
            n_page = i_page;
        end else if (w_shift) begin
            n_page = i_next_page;
        end else begin
            n_page = r_page;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;
    end

    assign o_page = r_page;

endmodule

/* design/lru_page_replacement_core.sv */
// LRU page replacement core: a row of recency slot cells with fault tracking.
// The result of a transaction is registered and appears on the output in the cycle after acceptance.
// Throughput: one page reference per cycle unless the output stalls; the slot row compares and shifts.
// The output register frees whenever the result is taken, so input stalls only on output backpressure.
// Reset (synchronous, active low) empties the store, clears the fault count and sets frame count to 4.
module lru_page_replacement_core #(
    parameter int MAX_FRAMES = lru_pkg::DEF_MAX_FRAMES,
    parameter int PAGE_WIDTH = lru_pkg::DEF_PAGE_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [lru_pkg::FC_WIDTH-1:0]    i_cfg_wdata,
    // page reference input
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [PAGE_WIDTH-1:0]           i_page_number,
    // result output
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_page_fault,
    output logic                            o_evict_valid,
    output logic [PAGE_WIDTH-1:0]           o_evicted_page,
    output logic [lru_pkg::FAULT_WIDTH-1:0] o_fault_total
);

    localparam int OCC_W = $clog2(MAX_FRAMES + 1);
    localparam int CW    = (OCC_W > lru_pkg::FC_WIDTH) ? OCC_W : lru_pkg::FC_WIDTH;

    logic [lru_pkg::FC_WIDTH-1:0]    r_frame_count;
    logic [OCC_W-1:0]                r_occ;
    logic [OCC_W-1:0]                n_occ;
    logic [lru_pkg::FAULT_WIDTH-1:0] r_faults;
    logic [lru_pkg::FAULT_WIDTH-1:0] n_faults;

    logic                            r_out_valid;
    logic                            r_out_fault;
    logic                            r_out_evict;
    logic [PAGE_WIDTH-1:0]           r_out_page;
    logic [lru_pkg::FAULT_WIDTH-1:0] r_out_total;

    logic                            w_accept;
    logic [CW-1:0]                   w_limit;
    logic [CW-1:0]                   w_fc_ext;
    logic                            w_hit;
    logic                            w_evict;
    lru_pkg::t_slot_cmd              w_cmd;

    logic [MAX_FRAMES:0]             w_chain;
    logic [MAX_FRAMES-1:0]           w_match;
    logic [PAGE_WIDTH-1:0]           w_slot_page [MAX_FRAMES];

    // Handshake: take a new transaction whenever the output register can be refilled
    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    // Effective frame limit, clamped to 1..MAX_FRAMES
    assign w_fc_ext = CW'(r_frame_count);
    always_comb begin
        priority if (w_fc_ext == '0) begin
            w_limit = CW'(1);
        end else if (w_fc_ext > CW'(MAX_FRAMES)) begin
            w_limit = CW'(MAX_FRAMES);
        end else begin
            w_limit = w_fc_ext;
        end
    end

    // Hit and eviction decisions from the slot row
    assign w_hit   = w_chain[MAX_FRAMES];
    assign w_evict = !w_hit && (CW'(r_occ) >= w_limit) && (r_occ != '0);

    assign w_cmd.accept = w_accept;
    assign w_cmd.hit    = w_hit;
    assign w_cmd.evict  = w_evict;

    // Slot row
    assign w_chain[0] = 1'b0;

    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_slot
        lru_pkg::t_slot_pos    w_pos;
        logic [PAGE_WIDTH-1:0] w_next;

        assign w_pos.live = OCC_W'(g) < r_occ;
        assign w_pos.last = OCC_W'(g + 1) == r_occ;
        assign w_pos.free = OCC_W'(g) == r_occ;

        if (g == MAX_FRAMES - 1) begin : g_top
            assign w_next = w_slot_page[g];
        end else begin : g_mid
            assign w_next = w_slot_page[g + 1];
        end

        lru_cell #(
            .PAGE_WIDTH (PAGE_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_page      (i_page_number),
            .i_pos       (w_pos),
            .i_cmd       (w_cmd),
            .i_hit_chain (w_chain[g]),
            .i_next_page (w_next),
            .o_hit_chain (w_chain[g + 1]),
            .o_match     (w_match[g]),
            .o_page      (w_slot_page[g])
        );
    end

    // Occupancy grows only on a miss that finds a free frame
    always_comb begin
        n_occ = r_occ;
        if (w_accept && !w_hit && !w_evict && ($countones(w_match) == 0)) begin
            n_occ = r_occ + OCC_W'(1);
        end
    end

    // Saturating fault count
    always_comb begin
        n_faults = r_faults;
        if (w_accept && !w_hit && (r_faults != lru_pkg::FAULT_MAX)) begin
            n_faults = r_faults + lru_pkg::FAULT_WIDTH'(1);
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= lru_pkg::FC_RESET;
            r_occ         <= '0;
            r_faults      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frame_count <= i_cfg_wdata;
            end
            r_occ    <= n_occ;
            r_faults <= n_faults;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_fault <= !w_hit;
            r_out_evict <= w_evict;
            r_out_page  <= w_evict ? w_slot_page[0] : '0;
            r_out_total <= n_faults;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_page_fault   = r_out_fault;
    assign o_evict_valid  = r_out_evict;
    assign o_evicted_page = r_out_page;
    assign o_fault_total  = r_out_total;

endmodule

/* design/lru_checker.sv */
// Port-level checks for the LRU page replacement core, bound to the top level.
module lru_checker #(
    parameter int PAGE_WIDTH = lru_pkg::DEF_PAGE_WIDTH
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic                            o_page_fault,
    input logic                            o_evict_valid,
    input logic [PAGE_WIDTH-1:0]           o_evicted_page,
    input logic [lru_pkg::FAULT_WIDTH-1:0] o_fault_total
);

    // Drop any pending result on reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Evict only on a fault
    a_evict_is_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_evict_valid |-> o_page_fault)
        else $error("eviction without page fault");

    // Evicted page reads zero when nothing is evicted
    a_evict_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_evict_valid |-> o_evicted_page == '0)
        else $error("evicted page nonzero without eviction");

    // A fault always leaves a nonzero total
    a_fault_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_page_fault |-> o_fault_total != '0)
        else $error("fault reported with zero total");

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_fault_total) &&
                                $stable(o_evicted_page))
        else $error("stalled result changed");

endmodule

bind lru_page_replacement_core lru_checker #(
    .PAGE_WIDTH (PAGE_WIDTH)
) u_lru_checker (.*);
